// ----- hdl/ftls_pkg.sv -----
// Shared types and constants for the four-way traffic light sequencer.
package ftls_pkg;

  localparam int NUM_APPR = 4;
  localparam int CNT_W    = 8;

  typedef enum logic [1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } lamp_t;

  typedef enum logic [1:0] {
    REG_GREEN_TIME = 2'd0,
    REG_RED_TIME   = 2'd1,
    REG_YELLOW_AT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             row;
    lamp_t            lamp;
  } appr_t;

  typedef struct packed {
    logic [CNT_W-1:0] green_time;
    logic [CNT_W-1:0] red_time;
    logic [CNT_W-1:0] yellow_at;
  } cfg_t;

  localparam logic [CNT_W-1:0] RST_GREEN_TIME = 8'd30;
  localparam logic [CNT_W-1:0] RST_RED_TIME   = 8'd90;
  localparam logic [CNT_W-1:0] RST_YELLOW_AT  = 8'd3;

  localparam logic [CNT_W-1:0] RST_COUNT [NUM_APPR] = '{8'd30, 8'd30, 8'd60, 8'd90};
  localparam logic             RST_ROW   [NUM_APPR] = '{1'b1, 1'b0, 1'b0, 1'b0};
  localparam lamp_t            RST_LAMP  [NUM_APPR] = '{LAMP_GREEN, LAMP_RED, LAMP_RED,
                                                        LAMP_RED};

endpackage

// ----- hdl/ftls_step.sv -----
// One approach visit: decrement, yellow switch, hand-off of right of way, or no change.
module ftls_step (
  input  ftls_pkg::cfg_t  cfg,
  input  ftls_pkg::appr_t cur_i,
  input  ftls_pkg::appr_t nxt_i,
  output ftls_pkg::appr_t cur_o,
  output ftls_pkg::appr_t nxt_o
);
  import ftls_pkg::*;

  logic [CNT_W-1:0] dec;

  assign dec = cur_i.count - 1'b1;

  always_comb begin
    cur_o = cur_i;
    nxt_o = nxt_i;
    if (cur_i.count != '0) begin
      cur_o.count = dec;
      if ((dec == cfg.yellow_at) && cur_i.row) begin
        cur_o.lamp = LAMP_YELLOW;
      end
    end else if (cur_i.row) begin
      cur_o.row   = 1'b0;
      cur_o.count = cfg.red_time;
      cur_o.lamp  = LAMP_RED;
      nxt_o.row   = 1'b1;
      nxt_o.count = cfg.green_time;
      nxt_o.lamp  = LAMP_GREEN;
    end
  end

endmodule

// ----- hdl/ftls_tick.sv -----
// One tick: visits approaches 0 to 3 in order through a chain of step cells.
module ftls_tick (
  input  ftls_pkg::cfg_t  cfg,
  input  ftls_pkg::appr_t st_i [ftls_pkg::NUM_APPR],
  output ftls_pkg::appr_t st_o [ftls_pkg::NUM_APPR]
);
  import ftls_pkg::*;

  appr_t stg [NUM_APPR+1][NUM_APPR];

  assign stg[0] = st_i;
  assign st_o   = stg[NUM_APPR];

  for (genvar k = 0; k < NUM_APPR; k++) begin : g_visit
    localparam int NK = (k + 1) % NUM_APPR;
    appr_t cur_o;
    appr_t nxt_o;

    ftls_step u_step (
      .cfg   (cfg),
      .cur_i (stg[k][k]),
      .nxt_i (stg[k][NK]),
      .cur_o (cur_o),
      .nxt_o (nxt_o)
    );

    always_comb begin
      stg[k+1]     = stg[k];
      stg[k+1][k]  = cur_o;
      stg[k+1][NK] = nxt_o;
    end
  end

endmodule

// ----- hdl/four_way_traffic_light_sequencer.sv -----
// Top level of the four-way traffic light sequencer: state, config and result register.
//
//   channel | direction | handshake        | payload
//   in_     | in        | valid / stall    | advance
//   out_    | out       | valid / stall    | count_a..count_d, lamp_a..lamp_d
//   cfg_    | in        | valid / ready    | index, data
//
// One beat per cycle unless stalled; results appear the cycle after acceptance.
// The whole tick is one pass through the four-cell step chain before the state registers.
// Reset loads counts 30/30/60/90, approach 0 green, times 30/90/3; config always ready.
// Input stalls only while a result is held and the output is stalled.
module four_way_traffic_light_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_advance,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ftls_pkg::CNT_W-1:0] out_count_a,
  output logic [ftls_pkg::CNT_W-1:0] out_count_b,
  output logic [ftls_pkg::CNT_W-1:0] out_count_c,
  output logic [ftls_pkg::CNT_W-1:0] out_count_d,
  output logic [1:0]                out_lamp_a,
  output logic [1:0]                out_lamp_b,
  output logic [1:0]                out_lamp_c,
  output logic [1:0]                out_lamp_d,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ftls_pkg::CNT_W-1:0] cfg_data
);
  import ftls_pkg::*;

  cfg_t  cfg_r;
  appr_t st_r   [NUM_APPR];
  appr_t st_tk  [NUM_APPR];
  appr_t st_nxt [NUM_APPR];
  appr_t out_r  [NUM_APPR];
  logic  out_valid_r;
  logic  out_valid_nxt;
  logic  in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_time <= RST_GREEN_TIME;
      cfg_r.red_time   <= RST_RED_TIME;
      cfg_r.yellow_at  <= RST_YELLOW_AT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GREEN_TIME: cfg_r.green_time <= cfg_data;
        REG_RED_TIME:   cfg_r.red_time   <= cfg_data;
        REG_YELLOW_AT:  cfg_r.yellow_at  <= cfg_data;
        default: ;
      endcase
    end
  end

  ftls_tick u_tick (
    .cfg  (cfg_r),
    .st_i (st_r),
    .st_o (st_tk)
  );

  always_comb begin
    st_nxt = st_r;
    if (in_acc && in_advance) begin
      st_nxt = st_tk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_APPR; i++) begin
        st_r[i].count <= RST_COUNT[i];
        st_r[i].row   <= RST_ROW[i];
        st_r[i].lamp  <= RST_LAMP[i];
      end
    end else begin
      st_r <= st_nxt;
    end
  end

  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= st_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count_a = out_r[0].count;
  assign out_count_b = out_r[1].count;
  assign out_count_c = out_r[2].count;
  assign out_count_d = out_r[3].count;
  assign out_lamp_a  = out_r[0].lamp;
  assign out_lamp_b  = out_r[1].lamp;
  assign out_lamp_c  = out_r[2].lamp;
  assign out_lamp_d  = out_r[3].lamp;

  logic [NUM_APPR-1:0] row_vec;
  logic [NUM_APPR-1:0] lit_vec;

  always_comb begin
    for (int i = 0; i < NUM_APPR; i++) begin
      row_vec[i] = st_r[i].row;
      lit_vec[i] = (st_r[i].lamp != LAMP_RED);
    end
  end

  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(row_vec))
    else $error("right of way not held by exactly one approach");

  a_lit_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    (lit_vec & ~row_vec) == '0)
    else $error("green or yellow lamp without right of way");

  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_advance) |=> ($stable(row_vec) && $stable(lit_vec)
      && $stable(st_r[0].count) && $stable(st_r[1].count)
      && $stable(st_r[2].count) && $stable(st_r[3].count)))
    else $error("state changed on a status-only beat");

endmodule
